>>> rtl/bpt_pkg.sv
// ============================================================================
// Breakpoint table package
// Shared constants, codes and structures of the breakpoint table with hit skip.
// ============================================================================
package bpt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_WIDTH  = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int HITS_W      = 17;

    localparam logic [HITS_W-1:0] HITS_MAX = '1;
    localparam logic [15:0] ADDR_MASK =
        (ADDR_WIDTH >= 16) ? 16'hFFFF : 16'((17'd1 << ADDR_WIDTH) - 17'd1);

    typedef enum logic [3:0] {
        OP_CHECK    = 4'd0,
        OP_ADD      = 4'd1,
        OP_REM_IDX  = 4'd2,
        OP_REM_ADDR = 4'd3,
        OP_REPLACE  = 4'd4,
        OP_EN_IDX   = 4'd5,
        OP_EN_ADDR  = 4'd6,
        OP_QRY_ADDR = 4'd7,
        OP_QRY_IDX  = 4'd8,
        OP_SET_STOP = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        STOP_OFF  = 2'd0,
        STOP_ADDR = 2'd1,
        STOP_ANY  = 2'd2
    } stop_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_SCAN,
        S_ACT,
        S_REPL,
        S_SHIFT,
        S_SH_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [15:0]       addr;
        logic              en;
        logic [15:0]       skip;
        logic [HITS_W-1:0] hits;
    } entry_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] addr;
        logic [3:0]  index;
        logic [15:0] skip_count;
        logic        enable_value;
        logic        stop_any;
    } item_t;

    typedef struct packed {
        logic        hit;
        status_t     status;
        logic        found;
        logic        found_enabled;
        logic        found_conditional;
        logic [15:0] found_addr;
        logic [4:0]  entry_count;
        logic        active;
    } res_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } mem_rd_t;

endpackage

>>> rtl/bpt_mem.sv
// ============================================================================
// Breakpoint entry store
// One write port and one read port with registered read data.
// ============================================================================
module bpt_mem
    import bpt_pkg::*;
(
    input  logic    clk,
    input  mem_wr_t wr,
    input  mem_rd_t rd,
    output entry_t  rd_data
);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/bpt_seq.sv
// ============================================================================
// Breakpoint table sequencer
// Scans, updates and compacts the entry store one entry at a time.
// ============================================================================
module bpt_seq
    import bpt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    input  logic    out_free,
    output logic    idle,
    output logic    done,
    output res_t    res,
    output mem_wr_t mem_wr,
    output mem_rd_t mem_rd,
    input  entry_t  rd_data
);

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [15:0]       addr_reg, addr_next;
    logic [3:0]        index_reg, index_next;
    logic [15:0]       skip_reg, skip_next;
    logic              en_reg, en_next;
    logic              any_reg, any_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    stop_t             stop_mode_reg, stop_mode_next;
    logic [15:0]       stop_addr_reg, stop_addr_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [IDX_W-1:0]  chk_reg, chk_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    res_t              res_reg, res_next;

    logic              idx_ok;
    logic [HITS_W-1:0] hits_inc;
    entry_t            upd;

    assign idx_ok = 32'(index_reg) < 32'(used_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            stop_mode_reg <= STOP_OFF;
            stop_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            stop_mode_reg <= stop_mode_next;
            stop_addr_reg <= stop_addr_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        addr_reg  <= addr_next;
        index_reg <= index_next;
        skip_reg  <= skip_next;
        en_reg    <= en_next;
        any_reg   <= any_next;
        ptr_reg   <= ptr_next;
        chk_reg   <= chk_next;
        pos_reg   <= pos_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        index_next     = index_reg;
        skip_next      = skip_reg;
        en_next        = en_reg;
        any_next       = any_reg;
        used_next      = used_reg;
        stop_mode_next = stop_mode_reg;
        stop_addr_next = stop_addr_reg;
        ptr_next       = ptr_reg;
        chk_next       = chk_reg;
        rd_vld_next    = rd_vld_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;
        mem_wr         = '0;
        mem_rd         = '0;
        done           = 1'b0;
        upd            = rd_data;
        hits_inc       = (rd_data.hits == HITS_MAX) ? rd_data.hits : rd_data.hits + 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = item.op;
                    addr_next  = item.addr & ADDR_MASK;
                    index_next = item.index;
                    skip_next  = item.skip_count;
                    en_next    = item.enable_value;
                    any_next   = item.stop_any;
                    res_next   = '0;
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                ptr_next    = '0;
                rd_vld_next = 1'b0;
                found_next  = 1'b0;
                case (op_reg) inside
                    OP_CHECK:
                    begin
                        if (stop_mode_reg == STOP_ANY ||
                            (stop_mode_reg == STOP_ADDR && addr_reg == stop_addr_reg))
                        begin
                            stop_mode_next = STOP_OFF;
                            res_next.hit   = 1'b1;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    OP_ADD, OP_REM_ADDR, OP_REPLACE, OP_EN_ADDR, OP_QRY_ADDR:
                    begin
                        state_next = S_SCAN;
                    end
                    OP_REM_IDX:
                    begin
                        if (idx_ok)
                        begin
                            ptr_next   = CNT_W'(index_reg);
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            res_next.status = ST_IGNORED;
                            state_next      = S_DONE;
                        end
                    end
                    OP_EN_IDX, OP_QRY_IDX:
                    begin
                        if (idx_ok)
                        begin
                            mem_rd.en   = 1'b1;
                            mem_rd.addr = IDX_W'(index_reg);
                            found_next  = 1'b1;
                            pos_next    = IDX_W'(index_reg);
                            state_next  = S_ACT;
                        end
                        else
                        begin
                            res_next.status = ST_IGNORED;
                            state_next      = S_DONE;
                        end
                    end
                    OP_SET_STOP:
                    begin
                        stop_addr_next = addr_reg;
                        stop_mode_next = any_reg ? STOP_ANY : STOP_ADDR;
                        state_next     = S_DONE;
                    end
                    default:
                    begin
                        res_next.status = ST_IGNORED;
                        state_next      = S_DONE;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (rd_vld_reg && rd_data.addr == addr_reg)
                begin
                    found_next  = 1'b1;
                    pos_next    = chk_reg;
                    rd_vld_next = 1'b0;
                    state_next  = S_ACT;
                end
                else if (ptr_reg < used_reg)
                begin
                    mem_rd.en   = 1'b1;
                    mem_rd.addr = ptr_reg[IDX_W-1:0];
                    rd_vld_next = 1'b1;
                    chk_next    = ptr_reg[IDX_W-1:0];
                    ptr_next    = ptr_reg + 1'b1;
                end
                else
                begin
                    found_next  = 1'b0;
                    rd_vld_next = 1'b0;
                    state_next  = S_ACT;
                end
            end

            S_ACT:
            begin
                state_next = S_DONE;
                case (op_reg) inside
                    OP_CHECK:
                    begin
                        if (found_reg && rd_data.en)
                        begin
                            upd.hits     = hits_inc;
                            mem_wr.en    = 1'b1;
                            mem_wr.addr  = pos_reg;
                            mem_wr.data  = upd;
                            res_next.hit = hits_inc > {1'b0, rd_data.skip};
                        end
                    end
                    OP_ADD:
                    begin
                        if (found_reg)
                        begin
                            res_next.status = ST_IGNORED;
                        end
                        else if (32'(used_reg) >= TABLE_DEPTH)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            mem_wr.en        = 1'b1;
                            mem_wr.addr      = used_reg[IDX_W-1:0];
                            mem_wr.data.addr = addr_reg;
                            mem_wr.data.en   = 1'b1;
                            mem_wr.data.skip = skip_reg;
                            mem_wr.data.hits = '0;
                            used_next        = used_reg + 1'b1;
                        end
                    end
                    OP_REM_ADDR:
                    begin
                        if (found_reg)
                        begin
                            ptr_next   = CNT_W'(pos_reg);
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            res_next.status = ST_IGNORED;
                        end
                    end
                    OP_REPLACE:
                    begin
                        if (found_reg || !idx_ok)
                        begin
                            res_next.status = ST_IGNORED;
                        end
                        else
                        begin
                            mem_rd.en   = 1'b1;
                            mem_rd.addr = IDX_W'(index_reg);
                            state_next  = S_REPL;
                        end
                    end
                    OP_EN_ADDR, OP_EN_IDX:
                    begin
                        if (found_reg)
                        begin
                            upd.en      = en_reg;
                            mem_wr.en   = 1'b1;
                            mem_wr.addr = pos_reg;
                            mem_wr.data = upd;
                        end
                        else
                        begin
                            res_next.status = ST_IGNORED;
                        end
                    end
                    OP_QRY_ADDR, OP_QRY_IDX:
                    begin
                        if (found_reg)
                        begin
                            res_next.found             = 1'b1;
                            res_next.found_enabled     = rd_data.en;
                            res_next.found_conditional = rd_data.skip != '0;
                            res_next.found_addr        = rd_data.addr;
                        end
                        else
                        begin
                            res_next.status = ST_IGNORED;
                        end
                    end
                    default:
                    begin
                        res_next.status = ST_IGNORED;
                    end
                endcase
            end

            S_REPL:
            begin
                upd.addr    = addr_reg;
                upd.hits    = '0;
                mem_wr.en   = 1'b1;
                mem_wr.addr = IDX_W'(index_reg);
                mem_wr.data = upd;
                state_next  = S_DONE;
            end

            S_SHIFT:
            begin
                if (ptr_reg + 1'b1 < used_reg)
                begin
                    mem_rd.en   = 1'b1;
                    mem_rd.addr = IDX_W'(ptr_reg + 1'b1);
                    state_next  = S_SH_WR;
                end
                else
                begin
                    used_next  = used_reg - 1'b1;
                    state_next = S_DONE;
                end
            end

            S_SH_WR:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = ptr_reg[IDX_W-1:0];
                mem_wr.data = rd_data;
                ptr_next    = ptr_reg + 1'b1;
                state_next  = S_SHIFT;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res             = res_reg;
        res.entry_count = 5'(used_reg);
        res.active      = (used_reg != '0) || (stop_mode_reg != STOP_OFF);
    end

    assign idle = (state_reg == S_IDLE);

endmodule

>>> rtl/breakpoint_table_with_hit_skip.sv
// ============================================================================
// Breakpoint table with hit skip
// Top level: stream ports, result register and the table sequencer.
// ============================================================================
// Each word passes through the idle state, a decode state and a state that
// presents the result, plus the work of the operation itself: an index
// operation reads its entry once and arming the soft stop adds no work, an
// address search reads the entries one at a time, a replacement adds one more
// read and write, and a removal reads and writes each entry shifted down. The
// work is set by the single read port of the entry store, which the sequencer
// walks one entry at a time. A finished result waits in the output register
// while the next word is taken.
module breakpoint_table_with_hit_skip
    import bpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // addr, index, skip_count, enable_value, stop_any
    input  logic [3:0]  s_tuser,  // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // hit, status, found, found_enabled,
                                  // found_conditional, found_addr, entry_count,
                                  // active
);

    item_t       item;
    res_t        res;
    mem_wr_t     mem_wr;
    mem_rd_t     mem_rd;
    entry_t      rd_data;
    logic        idle;
    logic        done;
    logic        out_free;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;

    assign item.op           = op_t'(s_tuser);
    assign item.addr         = s_tdata[15:0];
    assign item.index        = s_tdata[19:16];
    assign item.skip_count   = s_tdata[35:20];
    assign item.enable_value = s_tdata[36];
    assign item.stop_any     = s_tdata[37];

    assign s_tready = idle;
    assign out_free = !m_tvalid_reg || m_tready;

    bpt_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (s_tvalid && s_tready),
        .item     (item),
        .out_free (out_free),
        .idle     (idle),
        .done     (done),
        .res      (res),
        .mem_wr   (mem_wr),
        .mem_rd   (mem_rd),
        .rd_data  (rd_data)
    );

    bpt_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_data (rd_data)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (done)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'b0000, res.active, res.entry_count, res.found_addr,
                             res.found_conditional, res.found_enabled, res.found,
                             res.status, res.hit};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input accepted again while a word is in progress.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(m_tdata[26:22]) <= TABLE_DEPTH)
        else $error("Entry count exceeds the table depth.");

    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[2:1] == ST_DONE)
        else $error("A query reported a found entry with a failing status.");

    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[2:1] == ST_DONE && !m_tdata[3])
        else $error("A hit was reported together with a query or failure.");

endmodule
